// ===== hw/rtl/rss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rocking stepper sequencer package
// Shared item types, command codes, configuration layout and reset values.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_ONE     = 8'h31;

    localparam logic [2:0] REG_NODE_ID    = 3'd0;
    localparam logic [2:0] REG_STEP_HALF  = 3'd1;
    localparam logic [2:0] REG_FWD_TIME   = 3'd2;
    localparam logic [2:0] REG_BACK_TIME  = 3'd3;
    localparam logic [2:0] REG_PAUSE_ODD  = 3'd4;
    localparam logic [2:0] REG_PAUSE_EVEN = 3'd5;
    localparam logic [2:0] REG_DIR_MASK   = 3'd6;

    localparam logic [7:0]  NODE_ID_RESET    = 8'd50;
    localparam logic [15:0] STEP_HALF_RESET  = 16'd200;
    localparam logic [15:0] FWD_TIME_RESET   = 16'd1500;
    localparam logic [15:0] BACK_TIME_RESET  = 16'd200;
    localparam logic [15:0] PAUSE_ODD_RESET  = 16'd100;
    localparam logic [15:0] PAUSE_EVEN_RESET = 16'd50;
    localparam logic [3:0]  DIR_MASK_RESET   = 4'd1;

    typedef enum logic [1:0] {
        FUNC_BYTE = 2'd0,
        FUNC_US   = 2'd1,
        FUNC_MS   = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_US    = 3'd1,
        OP_MS    = 3'd2,
        OP_START = 3'd3,
        OP_STOP  = 3'd4
    } op_kind_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0] step_lines;
        logic [3:0] dir_lines;
        logic [2:0] reply;
    } out_item_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [2:0] motor;
    } op_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QLVL_W-1:0] level;
    } q_status_t;

    typedef struct packed {
        logic [7:0]  node_id;
        logic [15:0] step_half_period;
        logic [15:0] forward_time;
        logic [15:0] back_time;
        logic [15:0] pause_odd_motors;
        logic [15:0] pause_even_motors;
        logic [3:0]  dir_idle_mask;
    } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rss_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rocking stepper sequencer front end
// Accepts items, gathers command bytes and classifies each item into an op.
// ----------------------------------------------------------------------------
module rss_front #(
    parameter int MOTORS = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire rss_pkg::in_item_t cmd_item,
    input  wire logic [7:0]        node_id,
    input  wire logic              q_full,
    output logic                   push,
    output rss_pkg::op_t           push_op
);
    import rss_pkg::*;

    localparam logic [7:0] CHAR_LAST = 8'(int'(CHAR_ZERO) + MOTORS);

    logic [1:0] cmd_count_reg, cmd_count_next;
    logic [7:0] cmd_first_reg, cmd_first_next;
    logic [7:0] cmd_second_reg, cmd_second_next;
    logic       accept;

    assign cmd_stall = q_full;
    assign accept    = cmd_valid && !q_full;
    assign push      = accept;

    always_comb
    begin
        cmd_count_next    = cmd_count_reg;
        cmd_first_next    = cmd_first_reg;
        cmd_second_next   = cmd_second_reg;
        push_op.kind      = OP_NONE;
        push_op.motor     = 3'd0;
        unique case (cmd_item.func)
            FUNC_BYTE:
            begin
                if (cmd_item.rx_byte == CHAR_NEWLINE)
                begin
                    if (cmd_first_reg == node_id)
                    begin
                        if (cmd_second_reg >= CHAR_ONE && cmd_second_reg <= CHAR_LAST)
                        begin
                            push_op.kind  = OP_START;
                            push_op.motor = 3'(cmd_second_reg - CHAR_ZERO);
                        end
                        else
                        begin
                            push_op.kind = OP_STOP;
                        end
                    end
                    cmd_count_next  = 2'd0;
                    cmd_first_next  = 8'd0;
                    cmd_second_next = 8'd0;
                end
                else if (cmd_count_reg == 2'd0)
                begin
                    cmd_first_next = cmd_item.rx_byte;
                    cmd_count_next = 2'd1;
                end
                else if (cmd_count_reg == 2'd1)
                begin
                    cmd_second_next = cmd_item.rx_byte;
                    cmd_count_next  = 2'd2;
                end
            end
            FUNC_US: push_op.kind = OP_US;
            FUNC_MS: push_op.kind = OP_MS;
            default: push_op.kind = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_count_reg  <= 2'd0;
            cmd_first_reg  <= 8'd0;
            cmd_second_reg <= 8'd0;
        end
        else if (accept)
        begin
            cmd_count_reg  <= cmd_count_next;
            cmd_first_reg  <= cmd_first_next;
            cmd_second_reg <= cmd_second_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rss_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rocking stepper sequencer op queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rss_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire rss_pkg::op_t  push_op,
    input  wire logic          pop,
    output rss_pkg::op_t       pop_op,
    output rss_pkg::q_status_t status
);
    import rss_pkg::*;

    localparam logic [QLVL_W-1:0] LVL_FULL = QLVL_W'(QDEPTH);
    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);

    op_t               slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0] level_reg, level_next;
    logic              do_push;
    logic              do_pop;

    assign status.empty = (level_reg == '0);
    assign status.full  = (level_reg == LVL_FULL);
    assign status.level = level_reg;
    assign pop_op       = slots_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rss_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rocking stepper sequencer back end
// Carries out ops: step timing, dwell phases and the registered result item.
// ----------------------------------------------------------------------------
module rss_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rss_pkg::cfg_t      cfg,
    input  wire logic               op_valid,
    input  wire rss_pkg::op_t       op,
    output logic                    op_take,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output rss_pkg::out_item_t      res_item
);
    import rss_pkg::*;

    typedef enum logic [1:0] {
        PH_FORWARD = 2'd0,
        PH_PAUSE_A = 2'd1,
        PH_BACK    = 2'd2,
        PH_PAUSE_B = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  active_reg, active_next;
    logic [15:0] step_el_reg, step_el_next;
    logic [15:0] phase_el_reg, phase_el_next;
    logic [3:0]  step_lv_reg, step_lv_next;
    logic [3:0]  dir_lv_reg, dir_lv_next;
    logic        res_valid_reg;
    out_item_t   res_item_reg, res_item_next;
    logic [2:0]  reply;
    logic [3:0]  motor_bit;
    logic [15:0] step_inc;
    logic [15:0] phase_inc;
    logic [15:0] phase_len;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    assign op_take   = op_valid && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;
    assign step_inc  = sat_inc(step_el_reg);
    assign phase_inc = sat_inc(phase_el_reg);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            motor_bit[i] = (active_reg == 3'(i + 1));
        end
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_FORWARD: phase_len = cfg.forward_time;
            PH_BACK:    phase_len = cfg.back_time;
            default:    phase_len = active_reg[0] ? cfg.pause_odd_motors
                                                  : cfg.pause_even_motors;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        active_next   = active_reg;
        step_el_next  = step_el_reg;
        phase_el_next = phase_el_reg;
        step_lv_next  = step_lv_reg;
        dir_lv_next   = dir_lv_reg;
        reply         = 3'd0;
        unique case (op.kind)
            OP_US:
            begin
                if (active_reg != 3'd0 && step_inc >= cfg.step_half_period)
                begin
                    step_lv_next = step_lv_reg ^ motor_bit;
                    step_el_next = 16'd0;
                end
                else
                begin
                    step_el_next = step_inc;
                end
            end
            OP_MS:
            begin
                if (active_reg != 3'd0)
                begin
                    if (phase_inc >= phase_len)
                    begin
                        phase_el_next = 16'd0;
                        unique case (phase_reg)
                            PH_FORWARD:
                            begin
                                dir_lv_next = (dir_lv_reg & ~motor_bit)
                                            | (~cfg.dir_idle_mask & motor_bit);
                                phase_next  = PH_PAUSE_A;
                            end
                            PH_PAUSE_A: phase_next = PH_BACK;
                            PH_BACK:
                            begin
                                dir_lv_next = (dir_lv_reg & ~motor_bit)
                                            | (cfg.dir_idle_mask & motor_bit);
                                phase_next  = PH_PAUSE_B;
                            end
                            default:    phase_next = PH_FORWARD;
                        endcase
                    end
                    else
                    begin
                        phase_el_next = phase_inc;
                    end
                end
            end
            OP_START:
            begin
                active_next   = op.motor;
                phase_next    = PH_FORWARD;
                phase_el_next = 16'd0;
                reply         = op.motor;
            end
            OP_STOP:  active_next = 3'd0;
            default:  active_next = active_reg;
        endcase
        res_item_next.step_lines = step_lv_next;
        res_item_next.dir_lines  = dir_lv_next;
        res_item_next.reply      = reply;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FORWARD;
            active_reg    <= 3'd0;
            step_el_reg   <= 16'd0;
            phase_el_reg  <= 16'd0;
            step_lv_reg   <= 4'd0;
            dir_lv_reg    <= DIR_MASK_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_take)
            begin
                phase_reg    <= phase_next;
                active_reg   <= active_next;
                step_el_reg  <= step_el_next;
                phase_el_reg <= phase_el_next;
                step_lv_reg  <= step_lv_next;
                dir_lv_reg   <= dir_lv_next;
            end
            if (!res_valid_reg || !res_stall)
            begin
                res_valid_reg <= op_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            res_item_reg <= res_item_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rocking_stepper_sequencer_core.sv =====
`default_nettype none
// Each accepted item is written into the op queue, then taken by the back end into its result register.
// Throughput: one item per cycle; the front end stalls only when the
// two-entry op queue is full, which happens only under result stall.
// Reset: asynchronous, active low; no motor running, all timers and command
// bytes cleared, step lines low, direction lines and registers at defaults.
// ----------------------------------------------------------------------------
// Rocking stepper sequencer core
// Parses serial commands and drives one of several steppers in a rocking
// forward, pause, back, pause pattern from microsecond and millisecond ticks.
// ----------------------------------------------------------------------------
module rocking_stepper_sequencer_core #(
    parameter int MOTORS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire rss_pkg::in_item_t  cmd_item,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output rss_pkg::out_item_t      res_item,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import rss_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    q_status_t q_status;
    logic      push;
    op_t       push_op;
    logic      pop;
    op_t       pop_op;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODE_ID:    cfg_next.node_id           = cfg_data[7:0];
                REG_STEP_HALF:  cfg_next.step_half_period  = cfg_data;
                REG_FWD_TIME:   cfg_next.forward_time      = cfg_data;
                REG_BACK_TIME:  cfg_next.back_time         = cfg_data;
                REG_PAUSE_ODD:  cfg_next.pause_odd_motors  = cfg_data;
                REG_PAUSE_EVEN: cfg_next.pause_even_motors = cfg_data;
                REG_DIR_MASK:   cfg_next.dir_idle_mask     = cfg_data[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id           <= NODE_ID_RESET;
            cfg_reg.step_half_period  <= STEP_HALF_RESET;
            cfg_reg.forward_time      <= FWD_TIME_RESET;
            cfg_reg.back_time         <= BACK_TIME_RESET;
            cfg_reg.pause_odd_motors  <= PAUSE_ODD_RESET;
            cfg_reg.pause_even_motors <= PAUSE_EVEN_RESET;
            cfg_reg.dir_idle_mask     <= DIR_MASK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rss_front #(
        .MOTORS (MOTORS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .node_id   (cfg_reg.node_id),
        .q_full    (q_status.full),
        .push      (push),
        .push_op   (push_op)
    );

    rss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .status  (q_status)
    );

    rss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .op_valid  (!q_status.empty),
        .op        (pop_op),
        .op_take   (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

`ifndef NO_ASSERTIONS
    a_reply_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_item.reply != 3'd0)) |-> (res_item.reply <= 3'(MOTORS)))
        else $error("reply names a motor that does not exist");

    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= QLVL_W'(QDEPTH))
        else $error("op queue level beyond its depth");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!q_status.empty))
        else $error("result appeared without a queued op");
`endif

endmodule
`default_nettype wire
